// ----- sv/bcm_pkg.sv -----
// bcm_pkg: types, register indexes, reset values and helpers shared by the
// beat-locked cutoff modulator. No dependencies.
`default_nettype none
package bcm_pkg;

    localparam int TICKS_PER_BEAT_DEF   = 48;
    localparam int SINE_TABLE_SIZE_DEF  = 1024;
    localparam int DECAY_TABLE_SIZE_DEF = 256;
    localparam int STEPS_PER_BAR        = 8;
    localparam int STEP_LG              = $clog2(STEPS_PER_BAR);

    localparam logic [12:0] HZ_MIN    = 13'd100;
    localparam logic [12:0] HZ_MAX    = 13'd8000;
    localparam logic [16:0] CUT_MIN_Q4 = 17'd1600;
    localparam logic [23:0] LFO_TOL   = 24'd655;
    localparam logic [16:0] CUT_TOL   = 17'd16;

    typedef enum logic [3:0] {
        CFG_ENABLE  = 4'd0,
        CFG_STUTTER = 4'd1,
        CFG_LOW     = 4'd2,
        CFG_HIGH    = 4'd3,
        CFG_BARS    = 4'd4,
        CFG_SWING   = 4'd5,
        CFG_BLIP    = 4'd6,
        CFG_MASK    = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  enable_bits;
        logic [1:0]  stutter_rate;
        logic [12:0] sweep_low_hz;
        logic [12:0] sweep_high_hz;
        logic [4:0]  sweep_length_bars;
        logic [6:0]  swing_percent;
        logic [10:0] blip_depth_q10;
        logic [7:0]  step_mask;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        enable_bits:       2'd2,
        stutter_rate:      2'd2,
        sweep_low_hz:      13'd600,
        sweep_high_hz:     13'd2000,
        sweep_length_bars: 5'd4,
        swing_percent:     7'd0,
        blip_depth_q10:    11'd0,
        step_mask:         8'hFF
    };

    typedef struct packed {
        logic clr_lfo;
        logic clr_cut;
    } t_cfg_evt;

    typedef struct packed {
        logic [31:0] tick_count;
        logic [9:0]  tempo_bpm;
    } t_in;

    typedef struct packed {
        logic        lfo_push;
        logic        sub_lfo_push;
        logic [23:0] lfo_rate_q16;
        logic        cutoff_push;
        logic [16:0] main_cutoff_q4;
        logic        sub_cutoff_push;
        logic [15:0] sub_cutoff_q4;
        logic        step_open;
    } t_out;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
        logic [31:0] quo;
        logic [31:0] rem;
    } t_alu_rsp;

    typedef enum logic {
        ALU_IDLE,
        ALU_DIV
    } t_alu_st;

    typedef enum logic [4:0] {
        S_IDLE, S_RATE, S_POS, S_IDX, S_T2, S_P1, S_P2, S_P3, S_SV, S_BASE,
        S_PIB, S_PIBQ, S_OFF, S_STEP, S_D, S_HM, S_HD, S_SQ, S_ENV, S_CUT, S_FIN
    } t_seq_st;

    function automatic logic [12:0] clamp_hz(input logic [12:0] v);
        logic [12:0] r;
        r = v;
        if (v < HZ_MIN) r = HZ_MIN;
        else if (v > HZ_MAX) r = HZ_MAX;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/bcm_alu.sv -----
// bcm_alu: shared arithmetic unit, registered 32x32 multiply and
// radix-2 restoring divide. Uses bcm_pkg.
`default_nettype none
module bcm_alu
    import bcm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    t_alu_st     r_st, n_st;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_div, n_div;
    logic [63:0] r_prod, n_prod;
    logic        r_done, n_done;
    logic [32:0] rem2, sub2;
    logic        ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ALU_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_div  <= n_div;
        r_prod <= n_prod;
    end

    assign rem2 = {r_rem, r_quo[31]};
    assign sub2 = rem2 - {1'b0, r_div};
    assign ge   = (rem2 >= {1'b0, r_div});

    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_prod = r_prod;
        n_done = 1'b0;
        case (r_st)
            ALU_IDLE: begin
                if (i_start) begin
                    if (i_req.op == OP_MUL) begin
                        n_prod = 64'(i_req.a) * 64'(i_req.b);
                        n_done = 1'b1;
                    end else begin
                        n_st  = ALU_DIV;
                        n_rem = '0;
                        n_quo = i_req.a;
                        n_div = i_req.b;
                        n_cnt = 5'd31;
                    end
                end
            end
            ALU_DIV: begin
                // one quotient bit per cycle, msb first
                n_rem = ge ? sub2[31:0] : rem2[31:0];
                n_quo = {r_quo[30:0], ge};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_st   = ALU_IDLE;
                    n_done = 1'b1;
                end
            end
            default: n_st = ALU_IDLE;
        endcase
    end

    assign o_rsp = '{done: r_done, prod: r_prod, quo: r_quo, rem: r_rem};

endmodule
`default_nettype wire

// ----- sv/bcm_seq.sv -----
// bcm_seq: sequencer and datapath registers; runs the LFO, sweep, swing
// and blip math through bcm_alu and holds the push state. Uses bcm_pkg.
`default_nettype none
module bcm_seq
    import bcm_pkg::*;
#(
    parameter int TICKS_PER_BEAT   = TICKS_PER_BEAT_DEF,
    parameter int SINE_TABLE_SIZE  = SINE_TABLE_SIZE_DEF,
    parameter int DECAY_TABLE_SIZE = DECAY_TABLE_SIZE_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_cfg_evt i_evt,
    input  wire logic     i_go,
    input  wire t_in      i_item,
    input  wire logic     i_slot_free,
    output logic          o_idle,
    output logic          o_res_valid,
    output t_out          o_res
);

    localparam int BAR    = 4 * TICKS_PER_BEAT;
    localparam int BAR_W  = $clog2(BAR + 1);
    localparam int PER_W  = $clog2(16 * BAR + 1);
    localparam int TPS_W  = $clog2(TICKS_PER_BEAT + 1);
    localparam int SIN_LG = $clog2(SINE_TABLE_SIZE);
    localparam int DEC_LG = $clog2(DECAY_TABLE_SIZE);

    // reciprocals for the divides by fixed values, exact over their input ranges
    localparam int RATE_S = 35;
    localparam longint unsigned RATE_M = ((64'd1 << RATE_S) + 64'd59) / 64'd60;
    localparam int PCT_S  = 19;
    localparam longint unsigned PCT_M  = ((64'd1 << PCT_S) + 64'd99) / 64'd100;
    localparam int TPB_LG = $clog2(TICKS_PER_BEAT);
    localparam int BAR_S  = 30 + TPB_LG;
    localparam longint unsigned BAR_M  =
        ((64'd1 << BAR_S) + 64'(TICKS_PER_BEAT) - 64'd1) / 64'(TICKS_PER_BEAT);

    t_seq_st r_st, n_st;
    logic    r_pend, n_pend;
    logic [31:0] r_tick, n_tick;
    logic [9:0]  r_bpm, n_bpm;
    logic [23:0] r_rate, n_rate;
    logic [PER_W-1:0] r_pos, n_pos;
    logic [SIN_LG-1:0] r_idx, n_idx;
    logic [16:0] r_t2, n_t2;
    logic [16:0] r_p, n_p;
    logic [15:0] r_sp, n_sp;
    logic [16:0] r_base, n_base;
    logic [BAR_W-1:0] r_pib, n_pib;
    logic        r_odd, n_odd;
    logic [TPS_W-1:0] r_off, n_off;
    logic [TPS_W-1:0] r_srem, n_srem;
    logic        r_open, n_open;
    logic [14:0] r_y, n_y;
    logic [16:0] r_h, n_h;
    logic [2:0]  r_k, n_k;
    logic [31:0] r_tmp, n_tmp;
    logic [16:0] r_cut, n_cut;
    logic [16:0] r_last_cut, n_last_cut;
    logic        r_cut_known, n_cut_known;
    logic [23:0] r_last_rate, n_last_rate;
    logic        r_lfo_known, n_lfo_known;

    t_alu_req req;
    t_alu_rsp rsp;
    logic     start;

    // config values, which only the user keeps stable while an item is in flight
    logic [9:0]  bpm_e;
    logic [12:0] bm;
    logic [12:0] lo_c, hi_c, lo_e;
    logic [16:0] lo4, hi4, span4;
    logic [15:0] half;
    logic [4:0]  bars;
    logic [PER_W-1:0] period;
    logic [3:0]  mult;
    logic [TPS_W:0] tps_sum, tps_sh;
    logic [TPS_W-1:0] tps;
    logic [6:0]  swing;
    logic [10:0] depth;
    logic [13:0] tsw;
    logic [17:0] p18;
    logic [1:0]  quad;
    logic [16:0] t;
    logic [BAR_W:0] sw_x;
    logic [BAR_W-1:0] swung;
    logic [16:0] v17;
    logic [14:0] v;
    logic [63:0] cprod;
    logic [STEP_LG-1:0] step;
    logic [31:0] pib_q, pib_full;
    logic [23:0] rate_diff;
    logic [16:0] cut_diff;
    logic        lfo_push, cut_push;

    assign bpm_e  = (r_bpm == 10'd0) ? 10'd1 : r_bpm;
    assign bm     = 13'(bpm_e) << i_cfg.stutter_rate;
    assign lo_c   = clamp_hz(i_cfg.sweep_low_hz);
    assign hi_c   = clamp_hz(i_cfg.sweep_high_hz);
    assign lo_e   = (lo_c > hi_c) ? hi_c : lo_c;
    assign lo4    = {lo_e, 4'b0};
    assign hi4    = {hi_c, 4'b0};
    assign span4  = hi4 - lo4;
    assign half   = span4[16:1];
    assign bars   = (i_cfg.sweep_length_bars == 5'd0) ? 5'd1 :
                    (i_cfg.sweep_length_bars > 5'd16) ? 5'd16 : i_cfg.sweep_length_bars;
    assign period = PER_W'(bars * BAR);
    assign mult   = 4'd1 << i_cfg.stutter_rate;
    assign tps_sum = (TPS_W + 1)'(TICKS_PER_BEAT) + (TPS_W + 1)'(mult[3:1]);
    assign tps_sh = tps_sum >> i_cfg.stutter_rate;
    assign tps    = (tps_sh == '0) ? TPS_W'(1) : tps_sh[TPS_W-1:0];
    assign swing  = (i_cfg.swing_percent > 7'd66) ? 7'd66 : i_cfg.swing_percent;
    assign depth  = (i_cfg.blip_depth_q10 > 11'd1024) ? 11'd1024 : i_cfg.blip_depth_q10;
    assign tsw    = 14'(tps) * 14'(swing);

    // sine index to quarter and mirrored phase
    assign p18  = 18'(r_idx) << (18 - SIN_LG);
    assign quad = p18[17:16];
    assign t    = quad[0] ? (17'h10000 - {1'b0, p18[15:0]}) : {1'b0, p18[15:0]};

    assign sw_x  = (BAR_W + 1)'(r_pib) + (BAR_W + 1)'(BAR) - (BAR_W + 1)'(r_off);
    assign swung = (sw_x >= (BAR_W + 1)'(BAR)) ? BAR_W'(sw_x - (BAR_W + 1)'(BAR))
                                               : sw_x[BAR_W-1:0];

    assign v17   = 17'(rsp.prod >> 17);
    assign v     = (v17 > 17'd32767) ? 15'h7FFF : v17[14:0];
    assign cprod = rsp.prod >> 26;
    assign step  = rsp.quo[STEP_LG-1:0];

    // bar position: quotient of tick/4 by ticks per beat, then remainder
    assign pib_q    = 32'(rsp.prod >> BAR_S);
    assign pib_full = r_tick - pib_q * 32'(BAR);

    assign rate_diff = (r_rate > r_last_rate) ? r_rate - r_last_rate : r_last_rate - r_rate;
    assign cut_diff  = (r_cut > r_last_cut) ? r_cut - r_last_cut : r_last_cut - r_cut;
    assign lfo_push  = !r_lfo_known || (rate_diff > LFO_TOL);
    assign cut_push  = !r_cut_known || (cut_diff > CUT_TOL);

    assign start = (r_st != S_IDLE) && (r_st != S_FIN) && !r_pend;

    bcm_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_pend      <= 1'b0;
            r_last_cut  <= '0;
            r_cut_known <= 1'b0;
            r_last_rate <= '0;
            r_lfo_known <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_pend      <= n_pend;
            r_last_cut  <= n_last_cut;
            r_cut_known <= n_cut_known;
            r_last_rate <= n_last_rate;
            r_lfo_known <= n_lfo_known;
        end
        r_tick <= n_tick;
        r_bpm  <= n_bpm;
        r_rate <= n_rate;
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_t2   <= n_t2;
        r_p    <= n_p;
        r_sp   <= n_sp;
        r_base <= n_base;
        r_pib  <= n_pib;
        r_odd  <= n_odd;
        r_off  <= n_off;
        r_srem <= n_srem;
        r_open <= n_open;
        r_y    <= n_y;
        r_h    <= n_h;
        r_k    <= n_k;
        r_tmp  <= n_tmp;
        r_cut  <= n_cut;
    end

    always_comb begin
        n_st = r_st;
        n_pend = r_pend;
        n_tick = r_tick;   n_bpm = r_bpm;   n_rate = r_rate; n_pos = r_pos;
        n_idx = r_idx;     n_t2 = r_t2;     n_p = r_p;       n_sp = r_sp;
        n_base = r_base;   n_pib = r_pib;   n_odd = r_odd;   n_off = r_off;
        n_srem = r_srem;   n_open = r_open; n_y = r_y;       n_h = r_h;
        n_k = r_k;         n_tmp = r_tmp;   n_cut = r_cut;
        n_last_cut = r_last_cut;   n_cut_known = r_cut_known;
        n_last_rate = r_last_rate; n_lfo_known = r_lfo_known;
        req = '{op: OP_MUL, a: 32'd0, b: 32'd0};
        o_res_valid = 1'b0;
        o_res = '0;

        if (start) n_pend = 1'b1;
        if (rsp.done) n_pend = 1'b0;

        case (r_st)
            S_IDLE: begin
                if (i_go && i_cfg.enable_bits[0]) begin
                    n_tick = i_item.tick_count;
                    n_bpm  = i_item.tempo_bpm;
                    n_st   = S_RATE;
                end
            end
            S_RATE: begin
                // rounded divide by 60 as a reciprocal multiply
                req = '{op: OP_MUL, a: {3'b0, bm, 16'b0} + 32'd30, b: 32'(RATE_M)};
                if (rsp.done) begin
                    n_rate = 24'(rsp.prod >> RATE_S);
                    n_st   = S_POS;
                end
            end
            S_POS: begin
                req = '{op: OP_DIV, a: r_tick, b: 32'(period)};
                if (rsp.done) begin
                    n_pos = rsp.rem[PER_W-1:0];
                    n_st  = S_IDX;
                end
            end
            S_IDX: begin
                req = '{op: OP_DIV, a: 32'(r_pos) << SIN_LG, b: 32'(period)};
                if (rsp.done) begin
                    n_idx = rsp.quo[SIN_LG-1:0];
                    n_st  = S_T2;
                end
            end
            S_T2: begin
                req = '{op: OP_MUL, a: 32'(t), b: 32'(t)};
                if (rsp.done) begin
                    n_t2 = 17'(rsp.prod >> 16);
                    n_st = S_P1;
                end
            end
            S_P1: begin
                req = '{op: OP_MUL, a: 32'd307, b: 32'(r_t2)};
                if (rsp.done) begin
                    n_p  = 17'd5223 - 17'(rsp.prod >> 16);
                    n_st = S_P2;
                end
            end
            S_P2: begin
                req = '{op: OP_MUL, a: 32'(r_p), b: 32'(r_t2)};
                if (rsp.done) begin
                    n_p  = 17'd42334 - 17'(rsp.prod >> 16);
                    n_st = S_P3;
                end
            end
            S_P3: begin
                req = '{op: OP_MUL, a: 32'(r_p), b: 32'(r_t2)};
                if (rsp.done) begin
                    n_p  = 17'd102944 - 17'(rsp.prod >> 16);
                    n_st = S_SV;
                end
            end
            S_SV: begin
                req = '{op: OP_MUL, a: 32'(r_p), b: 32'(t)};
                if (rsp.done) begin
                    // sine value offset by half scale, negative half cycle mirrored
                    n_sp = quad[1] ? 16'(17'd32768 - 17'(v)) : 16'(17'd32768 + 17'(v));
                    n_st = S_BASE;
                end
            end
            S_BASE: begin
                req = '{op: OP_MUL, a: 32'(half), b: 32'(r_sp)};
                if (rsp.done) begin
                    n_base = lo4 + 17'((rsp.prod + 64'd16384) >> 15);
                    n_st   = S_PIB;
                end
            end
            S_PIB: begin
                req = '{op: OP_MUL, a: r_tick >> 2, b: 32'(BAR_M)};
                if (rsp.done) begin
                    n_pib = pib_full[BAR_W-1:0];
                    n_st  = S_PIBQ;
                end
            end
            S_PIBQ: begin
                req = '{op: OP_DIV, a: 32'(r_pib), b: 32'(tps)};
                if (rsp.done) begin
                    n_odd = rsp.quo[0];
                    n_st  = S_OFF;
                end
            end
            S_OFF: begin
                // percent of a subdivision, divide by 100 as a reciprocal multiply
                req = '{op: OP_MUL, a: 32'(tsw), b: 32'(PCT_M)};
                if (rsp.done) begin
                    n_off = r_odd ? TPS_W'(rsp.prod >> PCT_S) : '0;
                    n_st  = S_STEP;
                end
            end
            S_STEP: begin
                req = '{op: OP_DIV, a: 32'(swung), b: 32'(tps)};
                if (rsp.done) begin
                    n_srem = rsp.rem[TPS_W-1:0];
                    n_open = i_cfg.step_mask[step];
                    if (!i_cfg.step_mask[step]) begin
                        n_cut = CUT_MIN_Q4;
                        n_st  = S_FIN;
                    end else if (depth == 11'd0) begin
                        n_cut = r_base;
                        n_st  = S_FIN;
                    end else begin
                        n_st = S_D;
                    end
                end
            end
            S_D: begin
                req = '{op: OP_DIV, a: 32'(r_srem) << DEC_LG, b: 32'(tps)};
                if (rsp.done) begin
                    n_y  = 15'(rsp.quo[DEC_LG-1:0]) << (15 - DEC_LG);
                    n_h  = 17'h10000;
                    n_k  = 3'd5;
                    n_st = S_HM;
                end
            end
            S_HM: begin
                req = '{op: OP_MUL, a: 32'(r_y), b: 32'(r_h)};
                if (rsp.done) begin
                    n_tmp = rsp.prod[31:0];
                    n_st  = S_HD;
                end
            end
            S_HD: begin
                // horner term of the exponential series
                req = '{op: OP_DIV, a: r_tmp, b: 32'({r_k, 16'b0})};
                if (rsp.done) begin
                    n_h = 17'h10000 - 17'(rsp.quo);
                    if (r_k == 3'd1) begin
                        n_k  = 3'd3;
                        n_st = S_SQ;
                    end else begin
                        n_k  = r_k - 3'd1;
                        n_st = S_HM;
                    end
                end
            end
            S_SQ: begin
                req = '{op: OP_MUL, a: 32'(r_h), b: 32'(r_h)};
                if (rsp.done) begin
                    n_h = 17'(rsp.prod >> 16);
                    n_k = r_k - 3'd1;
                    if (r_k == 3'd1) n_st = S_ENV;
                end
            end
            S_ENV: begin
                req = '{op: OP_MUL, a: 32'(depth), b: 32'(r_h)};
                if (rsp.done) begin
                    n_tmp = 32'h0400_0000 - rsp.prod[31:0];
                    n_st  = S_CUT;
                end
            end
            S_CUT: begin
                req = '{op: OP_MUL, a: 32'(r_base), b: r_tmp};
                if (rsp.done) begin
                    n_cut = (cprod < 64'(CUT_MIN_Q4)) ? CUT_MIN_Q4 : 17'(cprod);
                    n_st  = S_FIN;
                end
            end
            S_FIN: begin
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    o_res.lfo_push        = lfo_push;
                    o_res.sub_lfo_push    = lfo_push && i_cfg.enable_bits[1];
                    o_res.lfo_rate_q16    = r_rate;
                    o_res.cutoff_push     = cut_push;
                    o_res.main_cutoff_q4  = r_cut;
                    o_res.sub_cutoff_push = cut_push && i_cfg.enable_bits[1];
                    o_res.sub_cutoff_q4   = r_cut[16:1];
                    o_res.step_open       = r_open;
                    if (lfo_push) begin
                        n_last_rate = r_rate;
                        n_lfo_known = 1'b1;
                    end
                    if (cut_push) begin
                        n_last_cut  = r_cut;
                        n_cut_known = 1'b1;
                    end
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase

        if (i_evt.clr_lfo) n_lfo_known = 1'b0;
        if (i_evt.clr_cut) n_cut_known = 1'b0;
    end

    assign o_idle = (r_st == S_IDLE);

endmodule
`default_nettype wire

// ----- sv/beat_locked_cutoff_modulator.sv -----
// beat_locked_cutoff_modulator: top level with configuration registers,
// input handshake and output register. Uses bcm_pkg, bcm_seq, bcm_alu.
//
//  channel   direction  handshake                  payload
//  in        in         i_in_valid / o_in_ready    i_in  (t_in)
//  out       out        o_out_valid / i_out_ready  o_out (t_out)
//  cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// an item's time from acceptance to the next ready is set by the shared unit's divide
// (4 divides plus 9 multiplies, 6 more divides and 10 more multiplies when the blip
// is active, for the blip envelope)
// o_in_ready is high only while the sequencer is idle; items with the drone
// stopped are taken and give no result
// reset is synchronous, active low; a finished result waits in the output
// register while the next item is accepted
`default_nettype none
module beat_locked_cutoff_modulator
    import bcm_pkg::*;
#(
    parameter int TICKS_PER_BEAT   = TICKS_PER_BEAT_DEF,
    parameter int SINE_TABLE_SIZE  = SINE_TABLE_SIZE_DEF,
    parameter int DECAY_TABLE_SIZE = DECAY_TABLE_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);

    t_cfg     r_cfg, n_cfg;
    t_cfg_evt evt;
    logic     r_out_valid, n_out_valid;
    t_out     r_out, n_out;
    logic     seq_idle, res_valid, slot_free, cfg_we;
    t_out     res;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // register file, values truncated to their field width
    always_comb begin
        n_cfg = r_cfg;
        evt   = '0;
        if (cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:  n_cfg.enable_bits       = i_cfg_data[1:0];
                CFG_STUTTER: begin
                    n_cfg.stutter_rate = i_cfg_data[1:0];
                    evt.clr_lfo        = 1'b1;
                end
                CFG_LOW:     n_cfg.sweep_low_hz      = i_cfg_data;
                CFG_HIGH:    n_cfg.sweep_high_hz     = i_cfg_data;
                CFG_BARS:    n_cfg.sweep_length_bars = i_cfg_data[4:0];
                CFG_SWING: begin
                    n_cfg.swing_percent = i_cfg_data[6:0];
                    evt.clr_cut         = 1'b1;
                end
                CFG_BLIP: begin
                    n_cfg.blip_depth_q10 = i_cfg_data[10:0];
                    evt.clr_cut          = 1'b1;
                end
                CFG_MASK: begin
                    n_cfg.step_mask = i_cfg_data[7:0];
                    evt.clr_cut     = 1'b1;
                end
                default: ; // indexes past the list are dropped
            endcase
        end
    end

    assign o_in_ready = seq_idle;
    assign slot_free  = !r_out_valid || i_out_ready;

    bcm_seq #(
        .TICKS_PER_BEAT   (TICKS_PER_BEAT),
        .SINE_TABLE_SIZE  (SINE_TABLE_SIZE),
        .DECAY_TABLE_SIZE (DECAY_TABLE_SIZE)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_evt       (evt),
        .i_go        (i_in_valid && o_in_ready),
        .i_item      (i_in),
        .i_slot_free (slot_free),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register, loads only when empty or being drained
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (res_valid) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ----- sv/bcm_chk.sv -----
// bcm_chk: port-level checks for the beat-locked cutoff modulator and the
// bind that attaches them. Uses bcm_pkg.
`default_nettype none
module bcm_chk
    import bcm_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out
);

    // held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_sub_lfo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.sub_lfo_push |-> o_out.lfo_push)
        else $error("sub lfo push without main push");

    a_sub_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.sub_cutoff_q4 == o_out.main_cutoff_q4[16:1])
        else $error("sub cutoff not half of main");

    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.main_cutoff_q4 >= CUT_MIN_Q4)
        else $error("cutoff below floor");

    a_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.step_open |-> o_out.main_cutoff_q4 == CUT_MIN_Q4)
        else $error("closed step not at floor");

endmodule

bind beat_locked_cutoff_modulator bcm_chk u_bcm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire
